// ===== src/tpl_pkg.sv =====
// Shared types and constants of the tilt PID leveling block.
// No dependencies; used by tpl_ctrl, tpl_datapath and tilt_pid_leveling.
package tpl_pkg;

  localparam int QuatW   = 16;
  localparam int CfgW    = 16;
  localparam int CfgIdxW = 3;
  localparam int CfgNum  = 8;
  localparam int DeltaW  = 17;
  localparam int PitchW  = 15;
  localparam int CordW   = 38;   // CORDIC x/y, roll inputs grow to ~35 bits
  localparam int AngW    = 20;   // angle accumulator, 2^-16 rad
  localparam int SqW     = 58;   // square root working width
  localparam int PW      = 30;   // asin argument, Q.28 saturated
  localparam int ProdW   = 64;
  localparam int MulAW   = 33;
  localparam int MulBW   = 31;
  localparam int NumW    = 26;   // |e|*1024 plus rounding
  localparam int FracK   = 26;   // reciprocal scaling
  localparam int IntegW  = 32;

  localparam logic signed [AngW-1:0] HalfPi   = 20'sd102944;
  localparam logic signed [AngW-1:0] RollLim  = 20'sd25736;
  localparam logic signed [AngW-1:0] PitchLim = 20'sd12868;

  typedef enum logic [CfgIdxW-1:0] {
    REG_ROLL_KP, REG_ROLL_KI, REG_ROLL_KD,
    REG_PITCH_KP, REG_PITCH_KI, REG_PITCH_KD,
    REG_CORR_FLOOR, REG_CORR_CEIL
  } cfg_reg_t;

  typedef enum logic [4:0] {
    OP_NOP, OP_LOAD,
    OP_M0, OP_M1, OP_M2, OP_M3, OP_M4, OP_M5, OP_M6,
    OP_CPRE, OP_CITER, OP_REND,
    OP_PSQ, OP_SQINIT, OP_SQSTEP, OP_SQDONE, OP_PEND,
    OP_P0, OP_P1, OP_P2, OP_P3, OP_P4, OP_P5, OP_P6, OP_P7,
    OP_OUT
  } op_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_M0, ST_M1, ST_M2, ST_M3, ST_M4, ST_M5, ST_M6,
    ST_RPRE, ST_RITER, ST_REND,
    ST_PSQ, ST_SQINIT, ST_SQSTEP, ST_SQDONE,
    ST_PPRE, ST_PITER, ST_PEND,
    ST_P0, ST_P1, ST_P2, ST_P3, ST_P4, ST_P5, ST_P6, ST_P7,
    ST_DONE
  } state_t;

  typedef struct packed {
    op_t  op;
    logic axis;   // 0 roll, 1 pitch
  } dp_cmd_t;

  typedef struct packed {
    logic cy_zero;
    logic iter_last;
    logic bit_last;
  } dp_stat_t;

  function automatic logic signed [AngW-1:0] atan_tab(input logic [3:0] i);
    case (i)
      4'd0:    return 20'sd51472;
      4'd1:    return 20'sd30386;
      4'd2:    return 20'sd16055;
      4'd3:    return 20'sd8150;
      4'd4:    return 20'sd4091;
      4'd5:    return 20'sd2047;
      4'd6:    return 20'sd1024;
      4'd7:    return 20'sd512;
      4'd8:    return 20'sd256;
      4'd9:    return 20'sd128;
      4'd10:   return 20'sd64;
      4'd11:   return 20'sd32;
      4'd12:   return 20'sd16;
      4'd13:   return 20'sd8;
      4'd14:   return 20'sd4;
      default: return 20'sd2;
    endcase
  endfunction

endpackage

// ===== src/tpl_ctrl.sv =====
// Sequencer of the tilt PID leveling block: one state per datapath step.
// Depends on tpl_pkg.
module tpl_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  input  tpl_pkg::dp_stat_t  stat,
  output tpl_pkg::dp_cmd_t   cmd
);

  tpl_pkg::state_t state_r, state_nxt;
  logic axis_r, axis_nxt;
  logic out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tpl_pkg::ST_IDLE;
      axis_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      axis_r      <= axis_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    axis_nxt      = axis_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd.op        = tpl_pkg::OP_NOP;
    cmd.axis      = axis_r;
    case (state_r)
      tpl_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd.op    = tpl_pkg::OP_LOAD;
          state_nxt = tpl_pkg::ST_M0;
        end
      end
      tpl_pkg::ST_M0: begin cmd.op = tpl_pkg::OP_M0; state_nxt = tpl_pkg::ST_M1; end
      tpl_pkg::ST_M1: begin cmd.op = tpl_pkg::OP_M1; state_nxt = tpl_pkg::ST_M2; end
      tpl_pkg::ST_M2: begin cmd.op = tpl_pkg::OP_M2; state_nxt = tpl_pkg::ST_M3; end
      tpl_pkg::ST_M3: begin cmd.op = tpl_pkg::OP_M3; state_nxt = tpl_pkg::ST_M4; end
      tpl_pkg::ST_M4: begin cmd.op = tpl_pkg::OP_M4; state_nxt = tpl_pkg::ST_M5; end
      tpl_pkg::ST_M5: begin cmd.op = tpl_pkg::OP_M5; state_nxt = tpl_pkg::ST_M6; end
      tpl_pkg::ST_M6: begin cmd.op = tpl_pkg::OP_M6; state_nxt = tpl_pkg::ST_RPRE; end
      tpl_pkg::ST_RPRE: begin
        cmd.op    = tpl_pkg::OP_CPRE;
        state_nxt = tpl_pkg::ST_RITER;
      end
      tpl_pkg::ST_RITER: begin
        cmd.op = tpl_pkg::OP_CITER;
        if (stat.cy_zero || stat.iter_last) state_nxt = tpl_pkg::ST_REND;
      end
      tpl_pkg::ST_REND: begin
        cmd.op    = tpl_pkg::OP_REND;
        state_nxt = tpl_pkg::ST_PSQ;
      end
      tpl_pkg::ST_PSQ: begin
        cmd.op    = tpl_pkg::OP_PSQ;
        state_nxt = tpl_pkg::ST_SQINIT;
      end
      tpl_pkg::ST_SQINIT: begin
        cmd.op    = tpl_pkg::OP_SQINIT;
        state_nxt = tpl_pkg::ST_SQSTEP;
      end
      tpl_pkg::ST_SQSTEP: begin
        cmd.op = tpl_pkg::OP_SQSTEP;
        if (stat.bit_last) state_nxt = tpl_pkg::ST_SQDONE;
      end
      tpl_pkg::ST_SQDONE: begin
        cmd.op    = tpl_pkg::OP_SQDONE;
        state_nxt = tpl_pkg::ST_PPRE;
      end
      tpl_pkg::ST_PPRE: begin
        cmd.op    = tpl_pkg::OP_CPRE;
        state_nxt = tpl_pkg::ST_PITER;
      end
      tpl_pkg::ST_PITER: begin
        cmd.op = tpl_pkg::OP_CITER;
        if (stat.cy_zero || stat.iter_last) state_nxt = tpl_pkg::ST_PEND;
      end
      tpl_pkg::ST_PEND: begin
        cmd.op    = tpl_pkg::OP_PEND;
        axis_nxt  = 1'b0;
        state_nxt = tpl_pkg::ST_P0;
      end
      tpl_pkg::ST_P0: begin cmd.op = tpl_pkg::OP_P0; state_nxt = tpl_pkg::ST_P1; end
      tpl_pkg::ST_P1: begin cmd.op = tpl_pkg::OP_P1; state_nxt = tpl_pkg::ST_P2; end
      tpl_pkg::ST_P2: begin cmd.op = tpl_pkg::OP_P2; state_nxt = tpl_pkg::ST_P3; end
      tpl_pkg::ST_P3: begin cmd.op = tpl_pkg::OP_P3; state_nxt = tpl_pkg::ST_P4; end
      tpl_pkg::ST_P4: begin cmd.op = tpl_pkg::OP_P4; state_nxt = tpl_pkg::ST_P5; end
      tpl_pkg::ST_P5: begin cmd.op = tpl_pkg::OP_P5; state_nxt = tpl_pkg::ST_P6; end
      tpl_pkg::ST_P6: begin cmd.op = tpl_pkg::OP_P6; state_nxt = tpl_pkg::ST_P7; end
      tpl_pkg::ST_P7: begin
        cmd.op = tpl_pkg::OP_P7;
        if (axis_r) begin
          state_nxt = tpl_pkg::ST_DONE;
        end else begin
          axis_nxt  = 1'b1;
          state_nxt = tpl_pkg::ST_P0;
        end
      end
      tpl_pkg::ST_DONE: begin
        // wait for the output word slot to free up
        if (!out_valid_r || !out_stall) begin
          cmd.op        = tpl_pkg::OP_OUT;
          out_valid_nxt = 1'b1;
          state_nxt     = tpl_pkg::ST_IDLE;
        end
      end
      default: state_nxt = tpl_pkg::ST_IDLE;
    endcase
  end

  assign in_stall  = (state_r != tpl_pkg::ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

// ===== src/tpl_datapath.sv =====
// Datapath: config registers, shared multiplier, CORDIC, square root, PIDs.
// Depends on tpl_pkg; sequenced by tpl_ctrl.
module tpl_datapath #(
  parameter int SAMPLE_RATE_HZ = 50
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  tpl_pkg::dp_cmd_t                    cmd,
  output tpl_pkg::dp_stat_t                   stat,
  input  logic                                cfg_we,
  input  logic [tpl_pkg::CfgIdxW-1:0]         cfg_index,
  input  logic [tpl_pkg::CfgW-1:0]            cfg_wdata,
  input  logic signed [tpl_pkg::QuatW-1:0]    in_quat_w,
  input  logic signed [tpl_pkg::QuatW-1:0]    in_quat_x,
  input  logic signed [tpl_pkg::QuatW-1:0]    in_quat_y,
  input  logic signed [tpl_pkg::QuatW-1:0]    in_quat_z,
  output logic signed [15:0]                  out_roll_angle,
  output logic signed [tpl_pkg::PitchW-1:0]   out_pitch_angle,
  output logic signed [15:0]                  out_roll_corr,
  output logic signed [15:0]                  out_pitch_corr,
  output logic signed [tpl_pkg::DeltaW-1:0]   out_ankle_delta_0,
  output logic signed [tpl_pkg::DeltaW-1:0]   out_ankle_delta_1,
  output logic signed [tpl_pkg::DeltaW-1:0]   out_ankle_delta_2,
  output logic signed [tpl_pkg::DeltaW-1:0]   out_ankle_delta_3,
  output logic signed [tpl_pkg::DeltaW-1:0]   out_ankle_delta_4,
  output logic signed [tpl_pkg::DeltaW-1:0]   out_ankle_delta_5
);

  localparam int RateW  = $clog2(SAMPLE_RATE_HZ + 1);
  localparam int DerivW = 18 + RateW;
  localparam longint unsigned RecipVal = (64'd1 << tpl_pkg::FracK) / SAMPLE_RATE_HZ;
  localparam longint unsigned HalfRate = SAMPLE_RATE_HZ / 2;
  localparam logic signed [tpl_pkg::MulBW-1:0] RecipB = tpl_pkg::MulBW'(RecipVal);
  localparam logic signed [tpl_pkg::MulBW-1:0] RateB  = tpl_pkg::MulBW'(SAMPLE_RATE_HZ);
  localparam logic [tpl_pkg::NumW-1:0] RateN = tpl_pkg::NumW'(SAMPLE_RATE_HZ);
  localparam logic [tpl_pkg::NumW-1:0] HalfN = tpl_pkg::NumW'(HalfRate);
  localparam logic signed [33:0] IntMax = 34'sd2147483647;
  localparam logic signed [33:0] IntMin = -34'sd2147483648;
  localparam logic signed [tpl_pkg::ProdW-1:0] PLim = 64'sd268435456;
  localparam logic [tpl_pkg::SqW-1:0] SqTop = 58'd1 << 56;

  logic [tpl_pkg::CfgW-1:0] cfg_r [tpl_pkg::CfgNum];

  logic signed [tpl_pkg::QuatW-1:0] qw_r, qx_r, qy_r, qz_r;
  logic signed [tpl_pkg::ProdW-1:0] prod_r, prod_nxt, acc_r, acc_nxt;
  logic signed [tpl_pkg::CordW-1:0] cx_r, cx_nxt, cy_r, cy_nxt;
  logic signed [tpl_pkg::AngW-1:0]  ang_r, ang_nxt;
  logic [3:0]                       iter_r, iter_nxt;
  logic [tpl_pkg::SqW-1:0]          sq_n_r, sq_n_nxt, sq_r, sq_nxt, sq_bit_r, sq_bit_nxt;
  logic signed [tpl_pkg::PW-1:0]    p_r, p_nxt;
  logic signed [15:0]               roll_r, roll_nxt, pitch_r, pitch_nxt;
  logic [tpl_pkg::NumW-1:0]         num_r, num_nxt, q_r, q_nxt;
  logic signed [16:0]               diff_r, diff_nxt;
  logic signed [DerivW-1:0]         dr_r, dr_nxt;
  logic signed [15:0]               rc_r, rc_nxt, pc_r, pc_nxt;
  logic signed [tpl_pkg::IntegW-1:0] integ_r [2];
  logic signed [15:0]               prev_r [2];
  logic signed [tpl_pkg::IntegW-1:0] integ_wr;
  logic                             state_we;

  logic signed [tpl_pkg::MulAW-1:0] mul_a;
  logic signed [tpl_pkg::MulBW-1:0] mul_b;
  logic signed [tpl_pkg::ProdW-1:0] mul_p;

  logic signed [15:0] e, kp, ki, kd;
  logic [15:0]        abs_e;
  logic [tpl_pkg::NumW-1:0] num_c, rem, q_fix;
  logic signed [33:0] inc, isum;
  logic signed [tpl_pkg::CordW-1:0] dx, dy;
  logic signed [tpl_pkg::AngW-1:0]  ang_rnd;
  logic signed [tpl_pkg::ProdW-1:0] two_acc, rnd, lim_lo, lim_hi, pid_v;
  logic [tpl_pkg::SqW-1:0]          trial;
  logic signed [tpl_pkg::DeltaW-1:0] rc17, pc17;

  assign e     = cmd.axis ? pitch_r : roll_r;
  assign kp    = $signed(cmd.axis ? cfg_r[tpl_pkg::REG_PITCH_KP] : cfg_r[tpl_pkg::REG_ROLL_KP]);
  assign ki    = $signed(cmd.axis ? cfg_r[tpl_pkg::REG_PITCH_KI] : cfg_r[tpl_pkg::REG_ROLL_KI]);
  assign kd    = $signed(cmd.axis ? cfg_r[tpl_pkg::REG_PITCH_KD] : cfg_r[tpl_pkg::REG_ROLL_KD]);
  assign abs_e = e[15] ? 16'(-e) : 16'(e);
  assign num_c = (tpl_pkg::NumW'(abs_e) << 10) + HalfN;

  // shared multiplier, operands picked per step
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      tpl_pkg::OP_M0:  begin mul_a = tpl_pkg::MulAW'(qw_r); mul_b = tpl_pkg::MulBW'(qx_r); end
      tpl_pkg::OP_M1:  begin mul_a = tpl_pkg::MulAW'(qy_r); mul_b = tpl_pkg::MulBW'(qz_r); end
      tpl_pkg::OP_M2:  begin mul_a = tpl_pkg::MulAW'(qx_r); mul_b = tpl_pkg::MulBW'(qx_r); end
      tpl_pkg::OP_M3:  begin mul_a = tpl_pkg::MulAW'(qy_r); mul_b = tpl_pkg::MulBW'(qy_r); end
      tpl_pkg::OP_M4:  begin mul_a = tpl_pkg::MulAW'(qw_r); mul_b = tpl_pkg::MulBW'(qy_r); end
      tpl_pkg::OP_M5:  begin mul_a = tpl_pkg::MulAW'(qz_r); mul_b = tpl_pkg::MulBW'(qx_r); end
      tpl_pkg::OP_PSQ: begin mul_a = tpl_pkg::MulAW'(p_r);  mul_b = tpl_pkg::MulBW'(p_r);  end
      tpl_pkg::OP_P0: begin
        mul_a = tpl_pkg::MulAW'($signed({1'b0, num_c}));
        mul_b = RecipB;
      end
      tpl_pkg::OP_P1: begin
        mul_a = tpl_pkg::MulAW'($signed({1'b0,
                  prod_r[tpl_pkg::FracK+tpl_pkg::NumW-1:tpl_pkg::FracK]}));
        mul_b = RateB;
      end
      tpl_pkg::OP_P2:  begin mul_a = tpl_pkg::MulAW'(e);      mul_b = tpl_pkg::MulBW'(kp); end
      tpl_pkg::OP_P3:  begin mul_a = tpl_pkg::MulAW'(diff_r); mul_b = RateB; end
      tpl_pkg::OP_P4: begin
        mul_a = tpl_pkg::MulAW'(integ_r[cmd.axis]);
        mul_b = tpl_pkg::MulBW'(ki);
      end
      tpl_pkg::OP_P5:  begin mul_a = tpl_pkg::MulAW'(dr_r);   mul_b = tpl_pkg::MulBW'(kd); end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = tpl_pkg::ProdW'(mul_a) * tpl_pkg::ProdW'(mul_b);

  always_comb begin
    prod_nxt   = mul_p;
    acc_nxt    = acc_r;
    cx_nxt     = cx_r;
    cy_nxt     = cy_r;
    ang_nxt    = ang_r;
    iter_nxt   = iter_r;
    sq_n_nxt   = sq_n_r;
    sq_nxt     = sq_r;
    sq_bit_nxt = sq_bit_r;
    p_nxt      = p_r;
    roll_nxt   = roll_r;
    pitch_nxt  = pitch_r;
    num_nxt    = num_r;
    q_nxt      = q_r;
    diff_nxt   = diff_r;
    dr_nxt     = dr_r;
    rc_nxt     = rc_r;
    pc_nxt     = pc_r;
    state_we   = 1'b0;
    integ_wr   = integ_r[cmd.axis];

    dx      = cx_r >>> iter_r;
    dy      = cy_r >>> iter_r;
    ang_rnd = (ang_r + 20'sd4) >>> 3;
    two_acc = acc_r <<< 1;
    trial   = sq_r + sq_bit_r;
    rem     = num_r - prod_r[tpl_pkg::NumW-1:0];
    q_fix   = q_r + ((rem >= RateN) ? 26'd1 : 26'd0);
    inc     = e[15] ? -$signed(34'(q_fix)) : $signed(34'(q_fix));
    isum    = 34'(integ_r[cmd.axis]) + inc;
    rnd     = (acc_r + 64'sd131072) >>> 18;
    lim_lo  = 64'($signed(cfg_r[tpl_pkg::REG_CORR_FLOOR]));
    lim_hi  = 64'($signed(cfg_r[tpl_pkg::REG_CORR_CEIL]));
    pid_v   = (rnd < lim_lo) ? lim_lo : rnd;
    if (pid_v > lim_hi) pid_v = lim_hi;

    case (cmd.op)
      tpl_pkg::OP_M1: acc_nxt = prod_r;
      tpl_pkg::OP_M2: acc_nxt = acc_r + prod_r;
      tpl_pkg::OP_M3: begin
        cy_nxt  = tpl_pkg::CordW'(two_acc);
        acc_nxt = prod_r;
      end
      tpl_pkg::OP_M4: acc_nxt = acc_r + prod_r;
      tpl_pkg::OP_M5: begin
        cx_nxt  = tpl_pkg::CordW'(64'sd268435456 - two_acc);
        acc_nxt = prod_r;
      end
      tpl_pkg::OP_M6: acc_nxt = acc_r - prod_r;
      tpl_pkg::OP_CPRE: begin
        iter_nxt = 4'd0;
        ang_nxt  = '0;
        if (cx_r < 0) begin
          if (cy_r >= 0) begin
            cx_nxt  = cy_r;
            cy_nxt  = -cx_r;
            ang_nxt = tpl_pkg::HalfPi;
          end else begin
            cx_nxt  = -cy_r;
            cy_nxt  = cx_r;
            ang_nxt = -tpl_pkg::HalfPi;
          end
        end
      end
      tpl_pkg::OP_CITER: begin
        if (cy_r != 0) begin
          iter_nxt = iter_r + 4'd1;
          if (cy_r > 0) begin
            cx_nxt  = cx_r + dy;
            cy_nxt  = cy_r - dx;
            ang_nxt = ang_r + tpl_pkg::atan_tab(iter_r);
          end else begin
            cx_nxt  = cx_r - dy;
            cy_nxt  = cy_r + dx;
            ang_nxt = ang_r - tpl_pkg::atan_tab(iter_r);
          end
        end
      end
      tpl_pkg::OP_REND: begin
        if (ang_rnd > tpl_pkg::RollLim)       roll_nxt = 16'(tpl_pkg::RollLim);
        else if (ang_rnd < -tpl_pkg::RollLim) roll_nxt = 16'(-tpl_pkg::RollLim);
        else                                  roll_nxt = 16'(ang_rnd);
        if (two_acc > PLim)       p_nxt = tpl_pkg::PW'(PLim);
        else if (two_acc < -PLim) p_nxt = tpl_pkg::PW'(-PLim);
        else                      p_nxt = tpl_pkg::PW'(two_acc);
      end
      tpl_pkg::OP_SQINIT: begin
        sq_n_nxt   = SqTop - prod_r[tpl_pkg::SqW-1:0];
        sq_nxt     = '0;
        sq_bit_nxt = SqTop;
      end
      tpl_pkg::OP_SQSTEP: begin
        if (sq_n_r >= trial) begin
          sq_n_nxt = sq_n_r - trial;
          sq_nxt   = (sq_r >> 1) + sq_bit_r;
        end else begin
          sq_nxt   = sq_r >> 1;
        end
        sq_bit_nxt = sq_bit_r >> 2;
      end
      tpl_pkg::OP_SQDONE: begin
        cx_nxt = $signed(tpl_pkg::CordW'(sq_r));
        cy_nxt = tpl_pkg::CordW'(p_r);
      end
      tpl_pkg::OP_PEND: begin
        if (ang_rnd > tpl_pkg::PitchLim)       pitch_nxt = 16'(tpl_pkg::PitchLim);
        else if (ang_rnd < -tpl_pkg::PitchLim) pitch_nxt = 16'(-tpl_pkg::PitchLim);
        else                                   pitch_nxt = 16'(ang_rnd);
      end
      tpl_pkg::OP_P0: num_nxt = num_c;
      tpl_pkg::OP_P1: q_nxt = prod_r[tpl_pkg::FracK+tpl_pkg::NumW-1:tpl_pkg::FracK];
      tpl_pkg::OP_P2: begin
        // reciprocal quotient is low by at most one
        state_we = 1'b1;
        if (isum > IntMax)      integ_wr = tpl_pkg::IntegW'(IntMax);
        else if (isum < IntMin) integ_wr = tpl_pkg::IntegW'(IntMin);
        else                    integ_wr = tpl_pkg::IntegW'(isum);
        diff_nxt = 17'(e) - 17'(prev_r[cmd.axis]);
      end
      tpl_pkg::OP_P3: acc_nxt = prod_r <<< 10;
      tpl_pkg::OP_P4: dr_nxt = $signed(prod_r[DerivW-1:0]);
      tpl_pkg::OP_P5: acc_nxt = acc_r + prod_r;
      tpl_pkg::OP_P6: acc_nxt = acc_r + (prod_r <<< 10);
      tpl_pkg::OP_P7: begin
        if (cmd.axis) pc_nxt = 16'(pid_v);
        else          rc_nxt = 16'(pid_v);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r[tpl_pkg::REG_ROLL_KP]    <= 16'h0000;
      cfg_r[tpl_pkg::REG_ROLL_KI]    <= 16'h0000;
      cfg_r[tpl_pkg::REG_ROLL_KD]    <= 16'h0000;
      cfg_r[tpl_pkg::REG_PITCH_KP]   <= 16'h0000;
      cfg_r[tpl_pkg::REG_PITCH_KI]   <= 16'h0000;
      cfg_r[tpl_pkg::REG_PITCH_KD]   <= 16'h0000;
      cfg_r[tpl_pkg::REG_CORR_FLOOR] <= 16'h8000;
      cfg_r[tpl_pkg::REG_CORR_CEIL]  <= 16'h7FFF;
      integ_r[0] <= '0;
      integ_r[1] <= '0;
      prev_r[0]  <= '0;
      prev_r[1]  <= '0;
    end else begin
      if (cfg_we) cfg_r[cfg_index] <= cfg_wdata;
      if (state_we) begin
        integ_r[cmd.axis] <= integ_wr;
        prev_r[cmd.axis]  <= e;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == tpl_pkg::OP_LOAD) begin
      qw_r <= in_quat_w;
      qx_r <= in_quat_x;
      qy_r <= in_quat_y;
      qz_r <= in_quat_z;
    end
    prod_r   <= prod_nxt;
    acc_r    <= acc_nxt;
    cx_r     <= cx_nxt;
    cy_r     <= cy_nxt;
    ang_r    <= ang_nxt;
    iter_r   <= iter_nxt;
    sq_n_r   <= sq_n_nxt;
    sq_r     <= sq_nxt;
    sq_bit_r <= sq_bit_nxt;
    p_r      <= p_nxt;
    roll_r   <= roll_nxt;
    pitch_r  <= pitch_nxt;
    num_r    <= num_nxt;
    q_r      <= q_nxt;
    diff_r   <= diff_nxt;
    dr_r     <= dr_nxt;
    rc_r     <= rc_nxt;
    pc_r     <= pc_nxt;
  end

  assign rc17 = tpl_pkg::DeltaW'(rc_r);
  assign pc17 = tpl_pkg::DeltaW'(pc_r);

  // output word, held while the receiver stalls
  always_ff @(posedge clk) begin
    if (cmd.op == tpl_pkg::OP_OUT) begin
      out_roll_angle    <= roll_r;
      out_pitch_angle   <= tpl_pkg::PitchW'(pitch_r);
      out_roll_corr     <= rc_r;
      out_pitch_corr    <= pc_r;
      out_ankle_delta_0 <= rc17 + pc17;
      out_ankle_delta_1 <= pc17 - rc17;
      out_ankle_delta_2 <= rc17;
      out_ankle_delta_3 <= -rc17;
      out_ankle_delta_4 <= rc17 - pc17;
      out_ankle_delta_5 <= -rc17 - pc17;
    end
  end

  assign stat.cy_zero   = (cy_r == 0);
  assign stat.iter_last = (iter_r == 4'd15);
  assign stat.bit_last  = sq_bit_r[0];

endmodule

// ===== src/tilt_pid_leveling.sv =====
// Tilt PID leveling block: quaternion in, tilt angles, corrections and
// six ankle deltas out. Depends on tpl_pkg, tpl_ctrl and tpl_datapath.
//
// Usage:
//  - Input channel in_valid/in_stall carries one quaternion word (Q1.14).
//    The block takes a word only when idle, then works on it alone.
//  - One result word per input on out_valid/out_stall. The output register
//    holds a finished word while the receiver stalls; the next quaternion is
//    accepted meanwhile and its result waits in the sequencer until free.
//  - Processing time is set by the two 16-step CORDIC loops (either stops
//    early when y hits zero), the 29-step square root and two 8-step PID
//    passes on one shared multiplier. A new word is taken only once the
//    previous result has been handed to the output register.
//  - cfg_we/cfg_index/cfg_wdata write gain and limit registers, one per cycle;
//    the user must write only while no word is in flight, unchecked by the block.
//  - Synchronous active-low reset restores register defaults, clears both
//    integrators and previous errors, and drops out_valid.
module tilt_pid_leveling #(
  parameter int SAMPLE_RATE_HZ = 50
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [tpl_pkg::QuatW-1:0]    in_quat_w,
  input  logic signed [tpl_pkg::QuatW-1:0]    in_quat_x,
  input  logic signed [tpl_pkg::QuatW-1:0]    in_quat_y,
  input  logic signed [tpl_pkg::QuatW-1:0]    in_quat_z,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [15:0]                  out_roll_angle,
  output logic signed [tpl_pkg::PitchW-1:0]   out_pitch_angle,
  output logic signed [15:0]                  out_roll_corr,
  output logic signed [15:0]                  out_pitch_corr,
  output logic signed [tpl_pkg::DeltaW-1:0]   out_ankle_delta_0,
  output logic signed [tpl_pkg::DeltaW-1:0]   out_ankle_delta_1,
  output logic signed [tpl_pkg::DeltaW-1:0]   out_ankle_delta_2,
  output logic signed [tpl_pkg::DeltaW-1:0]   out_ankle_delta_3,
  output logic signed [tpl_pkg::DeltaW-1:0]   out_ankle_delta_4,
  output logic signed [tpl_pkg::DeltaW-1:0]   out_ankle_delta_5,
  input  logic                                cfg_we,
  input  logic [tpl_pkg::CfgIdxW-1:0]         cfg_index,
  input  logic [tpl_pkg::CfgW-1:0]            cfg_wdata
);

  tpl_pkg::dp_cmd_t  cmd;
  tpl_pkg::dp_stat_t stat;

  tpl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  tpl_datapath #(
    .SAMPLE_RATE_HZ (SAMPLE_RATE_HZ)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_quat_w         (in_quat_w),
    .in_quat_x         (in_quat_x),
    .in_quat_y         (in_quat_y),
    .in_quat_z         (in_quat_z),
    .out_roll_angle    (out_roll_angle),
    .out_pitch_angle   (out_pitch_angle),
    .out_roll_corr     (out_roll_corr),
    .out_pitch_corr    (out_pitch_corr),
    .out_ankle_delta_0 (out_ankle_delta_0),
    .out_ankle_delta_1 (out_ankle_delta_1),
    .out_ankle_delta_2 (out_ankle_delta_2),
    .out_ankle_delta_3 (out_ankle_delta_3),
    .out_ankle_delta_4 (out_ankle_delta_4),
    .out_ankle_delta_5 (out_ankle_delta_5)
  );

  // an accepted word keeps the block busy on the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input accepted while block still idle");

  a_out_after_write: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == tpl_pkg::OP_OUT) |=> out_valid)
    else $error("result word written but not presented");

  a_pitch_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_pitch_angle <= 15'sd12868) && (out_pitch_angle >= -15'sd12868)))
    else $error("pitch angle out of range");

  a_ankle_sum: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_ankle_delta_2 + out_ankle_delta_3) == 17'sd0))
    else $error("middle legs not opposite");

endmodule
